// ===== rtl/record_exchange_sort_by_key_unit_defines.svh =====
// Assertion macros shared by the record exchange sort unit.
`ifndef RECORD_EXCHANGE_SORT_BY_KEY_UNIT_DEFINES_SVH
`define RECORD_EXCHANGE_SORT_BY_KEY_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// The consequent must hold in the same cycle as the antecedent.
`define RXS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define RXS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RXS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define RXS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/rxs_pkg.sv =====
// Types, constants and the control program of the record exchange sort unit.
package rxs_pkg;

  // Default capacity of the record store.
  localparam int MaxRecordsDefault = 32;

  // One input item.
  typedef struct packed {
    logic [15:0] sort_key;
    logic [31:0] payload;
    logic        last_record;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [15:0] out_key;
    logic [31:0] out_payload;
    logic        out_last;
    logic        overflow;
  } out_item_t;

  // One stored record.
  typedef struct packed {
    logic [15:0] key;
    logic [31:0] payload;
  } rec_t;

  // Step counter of the sequencer and the addresses of its program.
  localparam int StepW = 3;
  typedef logic [StepW-1:0] step_t;

  localparam step_t StLoad    = 3'd0;
  localparam step_t StRdFirst = 3'd1;
  localparam step_t StLdRow   = 3'd2;
  localparam step_t StCmp     = 3'd3;
  localparam step_t StEmit    = 3'd4;
  localparam step_t StNext    = 3'd5;

  // Branch conditions of a control word.
  typedef enum logic [2:0] {
    CondAlways,
    CondLastIn,
    CondA1End,
    CondB1End,
    CondSlot
  } cond_t;

  // Read address select of the record store.
  typedef enum logic [1:0] {
    RdA,
    RdA1,
    RdB1
  } rd_sel_t;

  // One control word: branch, read select and datapath enables.
  typedef struct packed {
    cond_t   cond;
    step_t   tgt_t;
    step_t   tgt_f;
    rd_sel_t rd_sel;
    logic    take_in;
    logic    ld_row;
    logic    cmp;
    logic    emit;
    logic    advance;
  } ucode_t;

  // Control program. Each step branches to tgt_t when its condition holds,
  // otherwise to tgt_f.
  function automatic ucode_t ucode_rom(input step_t s);
    ucode_t w;
    w = '{cond: CondAlways, tgt_t: StLoad, tgt_f: StLoad, rd_sel: RdA,
          take_in: 1'b0, ld_row: 1'b0, cmp: 1'b0, emit: 1'b0, advance: 1'b0};
    case (s)
      StLoad: begin
        // Take records until one carries the last mark.
        w.cond    = CondLastIn;
        w.tgt_t   = StRdFirst;
        w.tgt_f   = StLoad;
        w.take_in = 1'b1;
      end
      StRdFirst: begin
        // Fetch the record at the first row position.
        w.cond  = CondAlways;
        w.tgt_t = StLdRow;
        w.tgt_f = StLdRow;
      end
      StLdRow: begin
        // Latch the row record and fetch the first later record.
        w.cond   = CondA1End;
        w.tgt_t  = StEmit;
        w.tgt_f  = StCmp;
        w.rd_sel = RdA1;
        w.ld_row = 1'b1;
      end
      StCmp: begin
        // Compare and swap one later record, fetch the next one.
        w.cond   = CondB1End;
        w.tgt_t  = StEmit;
        w.tgt_f  = StCmp;
        w.rd_sel = RdB1;
        w.cmp    = 1'b1;
      end
      StEmit: begin
        // Hand the finished row record to the output register.
        w.cond   = CondSlot;
        w.tgt_t  = StNext;
        w.tgt_f  = StEmit;
        w.rd_sel = RdA1;
        w.emit   = 1'b1;
      end
      StNext: begin
        // Move to the next row, or close the run.
        w.cond    = CondA1End;
        w.tgt_t   = StLoad;
        w.tgt_f   = StLdRow;
        w.rd_sel  = RdA1;
        w.advance = 1'b1;
      end
      default: begin
        w.cond  = CondAlways;
        w.tgt_t = StLoad;
        w.tgt_f = StLoad;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/rxs_store.sv =====
// Record store: one write port and one registered read port.
module rxs_store #(
  parameter int Depth = rxs_pkg::MaxRecordsDefault,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AddrW-1:0]  wr_addr,
  input  rxs_pkg::rec_t     wr_data,
  input  logic [AddrW-1:0]  rd_addr,
  output rxs_pkg::rec_t     rd_data
);
  import rxs_pkg::*;

  rec_t mem [Depth];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/record_exchange_sort_by_key_unit.sv =====
// Top level of the record exchange sort unit: microcoded sequencer and datapath.
// Records are stored as they are loaded. After the last record, the sequencer sorts
// the set by compare-swap steps on the store's single read port, one compare-swap
// per cycle, and emits one result per row. Synchronous active-low reset empties
// the store and returns the sequencer to loading; no clearing pass is needed.
`include "record_exchange_sort_by_key_unit_defines.svh"

module record_exchange_sort_by_key_unit #(
  parameter int MAX_RECORDS = rxs_pkg::MaxRecordsDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rxs_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rxs_pkg::out_item_t out_data
);
  import rxs_pkg::*;

  localparam int CntW  = $clog2(MAX_RECORDS + 1);
  localparam int AddrW = $clog2(MAX_RECORDS);

  typedef logic [CntW-1:0] cnt_t;

  step_t     step_r, step_nxt;
  ucode_t    uc;
  cnt_t      count_r, count_nxt;
  cnt_t      a_r, a_nxt;
  cnt_t      b_r, b_nxt;
  cnt_t      a_inc, b_inc;
  logic      drop_r, drop_nxt;
  rec_t      row_r, row_nxt;
  out_item_t out_r, out_nxt;
  logic      out_valid_r, out_valid_nxt;
  logic      cond_hit, slot, in_acc, full, swap;

  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  rec_t             wr_data;
  logic [AddrW-1:0] rd_addr;
  rec_t             rd_data;

  // Record store.
  rxs_store #(
    .Depth(MAX_RECORDS)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Control word decode, branch and datapath next values.
  always_comb begin
    uc     = ucode_rom(step_r);
    a_inc  = a_r + cnt_t'(1);
    b_inc  = b_r + cnt_t'(1);
    full   = (count_r == cnt_t'(MAX_RECORDS));
    slot   = !out_valid_r || !out_stall;
    in_acc = uc.take_in && in_valid;
    swap   = uc.cmp && (row_r.key > rd_data.key);

    case (uc.cond)
      CondAlways: cond_hit = 1'b1;
      CondLastIn: cond_hit = in_acc && in_data.last_record;
      CondA1End:  cond_hit = (a_inc == count_r);
      CondB1End:  cond_hit = (b_inc == count_r);
      CondSlot:   cond_hit = slot;
      default:    cond_hit = 1'b1;
    endcase
    step_nxt = cond_hit ? uc.tgt_t : uc.tgt_f;

    case (uc.rd_sel)
      RdA:     rd_addr = a_r[AddrW-1:0];
      RdA1:    rd_addr = a_inc[AddrW-1:0];
      RdB1:    rd_addr = b_inc[AddrW-1:0];
      default: rd_addr = a_r[AddrW-1:0];
    endcase

    count_nxt     = count_r;
    drop_nxt      = drop_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    row_nxt       = row_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;

    // Loading: store the record while there is room, else note the drop.
    if (in_acc) begin
      if (!full) begin
        count_nxt = count_r + cnt_t'(1);
      end else begin
        drop_nxt = 1'b1;
      end
    end

    // Start of a row: the row record is held in a register.
    if (uc.ld_row) begin
      row_nxt = rd_data;
      b_nxt   = a_inc;
    end

    // Compare-swap: the smaller record moves into the row register.
    if (uc.cmp) begin
      b_nxt = b_inc;
      if (swap) begin
        row_nxt = rd_data;
      end
    end

    // Emit the finished row record.
    if (uc.emit && slot) begin
      out_nxt       = '{row_r.key, row_r.payload, (a_inc == count_r), drop_r};
      out_valid_nxt = 1'b1;
    end

    // Next row, or empty the store at the end of the run.
    if (uc.advance) begin
      if (a_inc == count_r) begin
        count_nxt = '0;
        drop_nxt  = 1'b0;
        a_nxt     = '0;
      end else begin
        a_nxt = a_inc;
      end
    end

    // Store write: a loaded record, or the displaced row record on a swap.
    wr_en   = (in_acc && !full) || swap;
    wr_addr = uc.cmp ? b_r[AddrW-1:0] : count_r[AddrW-1:0];
    wr_data = uc.cmp ? row_r : rec_t'{in_data.sort_key, in_data.payload};
  end

  // Sequencer and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= StLoad;
      count_r     <= '0;
      drop_r      <= 1'b0;
      a_r         <= '0;
      b_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      count_r     <= count_nxt;
      drop_r      <= drop_nxt;
      a_r         <= a_nxt;
      b_r         <= b_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    row_r <= row_nxt;
    out_r <= out_nxt;
  end

  assign in_stall  = !uc.take_in;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Checks on the sequencer.
  `RXS_ASSERT_NOW(a_cmp_range, clk, rst_n, step_r == StCmp, (b_r > a_r) && (b_r < count_r), "compare index outside the row")
  `RXS_ASSERT_NOW(a_drop_full, clk, rst_n, drop_r, count_r == cnt_t'(MAX_RECORDS), "record dropped while the store had room")
  `RXS_ASSERT_NEXT(a_last_starts, clk, rst_n, (step_r == StLoad) && in_valid && in_data.last_record, step_r == StRdFirst, "last record did not start the sort")

endmodule

// ===== verif/tb_record_exchange_sort_by_key_unit.sv =====
// Self-checking testbench for the record exchange sort unit, with a built-in sort predictor.
`timescale 1ns / 1ps

module tb_record_exchange_sort_by_key_unit;

  localparam int Cap         = rxs_pkg::MaxRecordsDefault;
  localparam int DirRows     = 20;
  localparam int RandItems   = 350;
  localparam int CycleLimit  = 400000;
  localparam int SettleCycles = 64 + 4 * Cap;
  localparam int ReportLimit = 10;

  typedef struct {
    rxs_pkg::in_item_t  item;
    bit                 typed;
    rxs_pkg::out_item_t want;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  rxs_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  rxs_pkg::out_item_t out_data;

  // Predictor state: records held for the set now being loaded.
  rxs_pkg::rec_t held[Cap];
  int            held_count = 0;
  bit            held_dropped = 1'b0;

  rxs_pkg::out_item_t sorted_q[$];
  dir_row_t           dir_rows[DirRows];

  int         cycle_count = 0;
  int         mismatches = 0;
  int         results_seen = 0;
  int         records_sent = 0;
  int         sets_done = 0;
  int         overflow_sets = 0;
  int         largest_set = 0;
  int         burst_left = 0;
  logic [10:0] stall_phase = '0;

  record_exchange_sort_by_key_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic rxs_pkg::in_item_t record_item(input logic [15:0] key,
                                                    input logic [31:0] pay,
                                                    input logic lst);
    rxs_pkg::in_item_t it;
    it.sort_key    = key;
    it.payload     = pay;
    it.last_record = lst;
    return it;
  endfunction

  function automatic rxs_pkg::out_item_t sorted_item(input logic [15:0] key,
                                                     input logic [31:0] pay,
                                                     input logic lst,
                                                     input logic ovf);
    rxs_pkg::out_item_t r;
    r.out_key     = key;
    r.out_payload = pay;
    r.out_last    = lst;
    r.overflow    = ovf;
    return r;
  endfunction

  // Store one record; on the last mark, sort the held set and queue its results.
  task automatic absorb_record(input rxs_pkg::in_item_t it, input bit queue_results);
    rxs_pkg::rec_t      tmp;
    rxs_pkg::out_item_t res;
    if (held_count < Cap) begin
      held[held_count].key     = it.sort_key;
      held[held_count].payload = it.payload;
      held_count++;
    end else begin
      held_dropped = 1'b1;
    end
    if (it.last_record) begin
      // Every row position is compared against each later one in turn,
      // which fixes where records with equal keys end up.
      for (int a = 0; a + 1 < held_count; a++) begin
        for (int b = a + 1; b < held_count; b++) begin
          if (held[a].key > held[b].key) begin
            tmp     = held[a];
            held[a] = held[b];
            held[b] = tmp;
          end
        end
      end
      for (int k = 0; k < held_count; k++) begin
        res = sorted_item(held[k].key, held[k].payload, k + 1 == held_count, held_dropped);
        if (queue_results) sorted_q.push_back(res);
      end
      if (held_dropped) overflow_sets++;
      sets_done++;
      held_count   = 0;
      held_dropped = 1'b0;
    end
  endtask

  // Offer one record, sometimes idling first when a burst has run out.
  task automatic send_record(input rxs_pkg::in_item_t it, input bit typed,
                             input rxs_pkg::out_item_t want);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    records_sent++;
    if (typed) begin
      sorted_q.push_back(want);
      absorb_record(it, 1'b0);
    end else begin
      absorb_record(it, 1'b1);
    end
  endtask

  // Hold the sender off until every queued result has come out.
  task automatic drain_results();
    if (sorted_q.size() != 0) begin
      in_valid <= 1'b0;
      while (sorted_q.size() != 0) @(posedge clk);
    end
  endtask

  // The receiver stalls in phases: never, lightly, heavily, and on a fixed beat.
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1'b1;
    case (stall_phase[10:9])
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= ($urandom_range(0, 3) == 0);
      2'd2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_phase[1:0] != 2'd0);
    endcase
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin
    rxs_pkg::out_item_t exp_item;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (sorted_q.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit) begin
          $display("Unexpected result: key %h payload %h last %b overflow %b",
                   out_data.out_key, out_data.out_payload, out_data.out_last,
                   out_data.overflow);
        end
      end else begin
        exp_item = sorted_q.pop_front();
        if (out_data.out_key !== exp_item.out_key ||
            out_data.out_payload !== exp_item.out_payload ||
            out_data.out_last !== exp_item.out_last ||
            out_data.overflow !== exp_item.overflow) begin
          mismatches++;
          if (mismatches <= ReportLimit) begin
            $display("Result %0d wrong: expected key %h payload %h last %b overflow %b",
                     results_seen, exp_item.out_key, exp_item.out_payload,
                     exp_item.out_last, exp_item.overflow);
            $display("                  actual   key %h payload %h last %b overflow %b",
                     out_data.out_key, out_data.out_payload, out_data.out_last,
                     out_data.overflow);
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, sorted_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int          set_size;
    int          key_mode;
    int          pick;
    int          rand_items;
    logic [15:0] key;
    rxs_pkg::out_item_t none;

    none = '0;
    rand_items = 0;

    // Directed sets. Single-record sets have their result written out.
    dir_rows[0]  = '{record_item(16'h0000, 32'h0000_0000, 1'b1), 1'b1,
                     sorted_item(16'h0000, 32'h0000_0000, 1'b1, 1'b0)};
    dir_rows[1]  = '{record_item(16'hFFFF, 32'hFFFF_FFFF, 1'b1), 1'b1,
                     sorted_item(16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b0)};
    // Two records across the sign boundary of the key.
    dir_rows[2]  = '{record_item(16'h8000, 32'hAAAA_AAAA, 1'b0), 1'b0, none};
    dir_rows[3]  = '{record_item(16'h7FFF, 32'h5555_5555, 1'b1), 1'b0, none};
    // Repeated keys mixed with smaller ones.
    dir_rows[4]  = '{record_item(16'h0005, 32'h0000_0001, 1'b0), 1'b0, none};
    dir_rows[5]  = '{record_item(16'h0003, 32'h0000_0002, 1'b0), 1'b0, none};
    dir_rows[6]  = '{record_item(16'h0005, 32'h0000_0003, 1'b0), 1'b0, none};
    dir_rows[7]  = '{record_item(16'h0003, 32'h0000_0004, 1'b0), 1'b0, none};
    dir_rows[8]  = '{record_item(16'h0001, 32'h0000_0005, 1'b1), 1'b0, none};
    // Strictly descending keys.
    dir_rows[9]  = '{record_item(16'hFFFF, 32'h0123_4567, 1'b0), 1'b0, none};
    dir_rows[10] = '{record_item(16'h1234, 32'h89AB_CDEF, 1'b0), 1'b0, none};
    dir_rows[11] = '{record_item(16'h0001, 32'hFEDC_BA98, 1'b0), 1'b0, none};
    dir_rows[12] = '{record_item(16'h0000, 32'h7654_3210, 1'b1), 1'b0, none};
    // All keys equal.
    dir_rows[13] = '{record_item(16'h4242, 32'h0000_00A1, 1'b0), 1'b0, none};
    dir_rows[14] = '{record_item(16'h4242, 32'h0000_00B2, 1'b0), 1'b0, none};
    dir_rows[15] = '{record_item(16'h4242, 32'h0000_00C3, 1'b0), 1'b0, none};
    dir_rows[16] = '{record_item(16'h4242, 32'h0000_00D4, 1'b1), 1'b0, none};
    // Already in order.
    dir_rows[17] = '{record_item(16'h0001, 32'h8000_0000, 1'b0), 1'b0, none};
    dir_rows[18] = '{record_item(16'h0002, 32'h0000_0001, 1'b0), 1'b0, none};
    dir_rows[19] = '{record_item(16'hFFFE, 32'hFFFF_FFFE, 1'b1), 1'b0, none};

    // Hold the synchronous reset, then release it.
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DirRows; r++) begin
      send_record(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].want);
    end
    drain_results();

    // Random sets: mostly small, some full, a few past capacity.
    while (rand_items < RandItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) set_size = $urandom_range(1, 6);
      else if (pick < 80) set_size = $urandom_range(7, Cap - 1);
      else if (pick < 90) set_size = Cap;
      else set_size = $urandom_range(Cap + 1, Cap + 8);
      if (set_size > largest_set) largest_set = set_size;
      key_mode = $urandom_range(0, 3);
      for (int i = 0; i < set_size; i++) begin
        case (key_mode)
          0: key = 16'($urandom_range(0, 16'hFFFF));
          1: key = 16'($urandom_range(0, 7));
          2: key = 16'($urandom_range(16'hFFF8, 16'hFFFF));
          default: begin
            case ($urandom_range(0, 3))
              0: key = 16'h0000;
              1: key = 16'hFFFF;
              2: key = 16'h8000;
              default: key = 16'h7FFF;
            endcase
          end
        endcase
        send_record(record_item(key, $urandom, i == set_size - 1), 1'b0, none);
        rand_items++;
      end
      // Now and then let the whole set drain before the next one.
      if ($urandom_range(0, 4) == 0) drain_results();
    end

    in_valid <= 1'b0;
    while (sorted_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);

    $display("Sorted %0d sets from %0d records (largest set %0d, %0d over capacity),",
             sets_done, records_sent, largest_set, overflow_sets);
    $display("checking %0d results under bursty input and phased output stalls.",
             results_seen);
    if (mismatches == 0 && sorted_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results never arrived.", mismatches, sorted_q.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/rxs_pkg.sv
rtl/rxs_store.sv
rtl/record_exchange_sort_by_key_unit.sv
verif/tb_record_exchange_sort_by_key_unit.sv
